/* design/extended_double_to_softfloat_core_macros.svh */
// Assertion macros for the extended double to soft-float converter
`ifndef EXTENDED_DOUBLE_TO_SOFTFLOAT_CORE_MACROS_SVH
`define EXTENDED_DOUBLE_TO_SOFTFLOAT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/edsf_pkg.sv */
// Shared types and constants for the extended double to soft-float converter
package edsf_pkg;
  localparam logic [30:0] EXP_ALL_ONES = 31'h7FFFFFFF;
  localparam logic [31:0] MANT_ALL_ONES = 32'hFFFFFFFF;
  localparam int SF_BIAS = 1073741823;
  localparam int PIPE_DEPTH = 3;

  // Stage 1 result: classified input, normalized significand, clamped scale
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [30:0] sp_exp;
    logic [31:0] sp_mant;
    logic [31:0] mant;
    logic [11:0] base_exp;
    logic [5:0]  shift;
    logic [31:0] scale;
  } stage1_t;

  // Stage 2 result: biased exponent sum ready for range check
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [30:0] sp_exp;
    logic [31:0] sp_mant;
    logic [31:0] mant;
    logic [33:0] sum;
  } stage2_t;
endpackage

/* design/edsf_unpack.sv */
// First stage: classify the double, find the leading one, clamp the scale
module edsf_unpack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [63:0]          double_bits,
  input  logic signed [63:0]   scale_exponent,
  output logic                 out_valid,
  output edsf_pkg::stage1_t    out_data
);
  logic [10:0] efield;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic [51:0] norm;
  logic [31:0] scale_c;
  edsf_pkg::stage1_t d;

  assign efield = double_bits[62:52];
  assign frac = double_bits[51:0];

  // Count leading zeros of the fraction for subnormals
  always_comb begin
    lz = 6'd51;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) lz = 6'(51 - i);
    end
  end

  assign norm = frac << lz;

  // Clamp scale to the 32-bit signed range
  always_comb begin
    if (scale_exponent > 64'sh7FFFFFFF) scale_c = 32'h7FFFFFFF;
    else if (scale_exponent < -64'sh80000000) scale_c = 32'h80000000;
    else scale_c = scale_exponent[31:0];
  end

  always_comb begin
    d.sign = double_bits[63];
    d.special = 1'b0;
    d.sp_exp = '0;
    d.sp_mant = '0;
    d.scale = scale_c;
    d.shift = '0;
    d.base_exp = {1'b0, efield};
    d.mant = {1'b1, frac[51:21]};
    if (efield == 11'h7FF) begin
      d.special = 1'b1;
      d.sp_exp = edsf_pkg::EXP_ALL_ONES;
      d.sp_mant = (frac != '0) ? edsf_pkg::MANT_ALL_ONES : '0;
    end else if (efield == '0 && frac == '0) begin
      d.special = 1'b1;
    end else if (efield == '0) begin
      // Subnormal: exponent is p - 1073 + bias with p = 51 - shift
      d.shift = lz;
      d.base_exp = 12'd0;
      d.mant = norm[51:20];
    end
  end

  // Advance stage register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    out_data <= d;
  end
endmodule

/* design/edsf_sum.sv */
// Second stage: form biased exponent plus clamped scale
module edsf_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  edsf_pkg::stage1_t    in_data,
  output logic                 out_valid,
  output edsf_pkg::stage2_t    out_data
);
  logic signed [33:0] be;
  edsf_pkg::stage2_t d;

  // Normal: e - 1022 + bias; subnormal: p - 1073 + bias, p = 51 - shift
  always_comb begin
    be = 34'(signed'({1'b0, in_data.base_exp})) - 34'sd1022 + 34'(edsf_pkg::SF_BIAS)
         - 34'(signed'({1'b0, in_data.shift}));
    d.sign = in_data.sign;
    d.special = in_data.special;
    d.sp_exp = in_data.sp_exp;
    d.sp_mant = in_data.sp_mant;
    d.mant = in_data.mant;
    d.sum = 34'(be + 34'(signed'(in_data.scale)));
  end

  // Advance stage register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    out_data <= d;
  end
endmodule

/* design/extended_double_to_softfloat_core.sv */
// Top level of the extended double to soft-float converter
// Usage: pulse start with double_bits and scale_exponent; busy is always low,
// so one request may be issued every cycle. Each request yields one result
// on sign_out, biased_exponent and mantissa_out, marked by done for exactly
// one cycle, once the request has passed the unpack, sum and output registers.
// Stages: classify/normalize and clamp, exponent sum, range check and output
// register. The leading-one search and the 34-bit exponent add set the stage
// depths. Reset clears the valid bits only; requests in flight are dropped.
// The receiver cannot stall: results must be taken in the cycle they appear.
// NaN gives all-ones exponent and mantissa, infinity all-ones exponent and
// zero mantissa, zero keeps its sign, overflow saturates to infinity and
// underflow flushes to signed zero.
`include "extended_double_to_softfloat_core_macros.svh"
module extended_double_to_softfloat_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        double_bits,
  input  logic signed [63:0] scale_exponent,
  output logic               done,
  output logic               sign_out,
  output logic [30:0]        biased_exponent,
  output logic [31:0]        mantissa_out
);
  logic              v1, v2;
  edsf_pkg::stage1_t s1;
  edsf_pkg::stage2_t s2;
  logic              accept;

  assign busy = 1'b0;
  assign accept = start && !busy;

  edsf_unpack u_unpack (.clk(clk), .rst(rst), .in_valid(accept), .double_bits(double_bits),
    .scale_exponent(scale_exponent), .out_valid(v1), .out_data(s1));
  edsf_sum u_sum (.clk(clk), .rst(rst), .in_valid(v1), .in_data(s1),
    .out_valid(v2), .out_data(s2));

  // Range check and output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v2;
    sign_out <= s2.sign;
    if (s2.special) begin
      biased_exponent <= s2.sp_exp;
      mantissa_out <= s2.sp_mant;
    end else if (!s2.sum[33] && s2.sum[32:0] >= 33'h7FFFFFFF) begin
      biased_exponent <= edsf_pkg::EXP_ALL_ONES;
      mantissa_out <= '0;
    end else if (s2.sum[33] || s2.sum == '0) begin
      biased_exponent <= '0;
      mantissa_out <= '0;
    end else begin
      biased_exponent <= s2.sum[30:0];
      mantissa_out <= s2.mant;
    end
  end

  `ASSERT_NEXT(a_latency, clk, rst, accept, v1)
  `ASSERT_NEXT(a_done, clk, rst, v2, done)
  `ASSERT_IMPL(a_norm, clk, rst, done && biased_exponent != '0
    && biased_exponent != edsf_pkg::EXP_ALL_ONES, mantissa_out[31])
endmodule
